// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg : text console writer shared definitions
// Screen geometry, derived widths, item classes and back-end states.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int COPY_COUNT  = COLUMNS * (ROWS - 1);

    // derived widths
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int COL_X_W     = COL_W + 1;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int CNT_W       = $clog2(CELL_COUNT + 1);

    // port field widths
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_W      = 16;
    localparam int INDEX_W     = 11;
    localparam int POS_W       = 11;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam int TAB_STEP    = 8;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // front/back queue, depth a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // item classes decided by the front end
    typedef enum logic [2:0] {
        OP_NONE,
        OP_READ,
        OP_PUT,
        OP_BACKSPACE,
        OP_TAB,
        OP_RETURN,
        OP_NEWLINE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [CHAR_W-1:0]   char_code;
        logic [INDEX_W-1:0]  cell_index;
    } q_entry_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL
    } back_state_t;

endpackage

// ===== rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front : input acceptance and classification
// Takes input beats and sorts each into an operation class for the queue.
// ----------------------------------------------------------------------------
module tcw_front (
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,
    input  logic                          clearing,
    input  logic                          q_full,
    output logic                          push,
    output tcw_pkg::q_entry_t             push_entry
);

    tcw_pkg::op_t op;

    // hold off while the queue is full or the screen is being cleared
    assign in_ready = !q_full && !clearing;
    assign push     = in_valid && in_ready;

    // classify the beat
    always_comb
    begin
        op = tcw_pkg::OP_NONE;
        if (command == tcw_pkg::CMD_READ)
        begin
            op = tcw_pkg::OP_READ;
        end
        else if (char_code == tcw_pkg::CH_BACKSPACE)
        begin
            op = tcw_pkg::OP_BACKSPACE;
        end
        else if (char_code == tcw_pkg::CH_TAB)
        begin
            op = tcw_pkg::OP_TAB;
        end
        else if (char_code == tcw_pkg::CH_RETURN)
        begin
            op = tcw_pkg::OP_RETURN;
        end
        else if (char_code == tcw_pkg::CH_NEWLINE)
        begin
            op = tcw_pkg::OP_NEWLINE;
        end
        else if (char_code >= tcw_pkg::CH_SPACE)
        begin
            op = tcw_pkg::OP_PUT;
        end
    end

    assign push_entry.op         = op;
    assign push_entry.char_code  = char_code;
    assign push_entry.cell_index = cell_index;

endmodule

// ===== rtl/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// tcw_queue : short queue between front and back ends
// Small register queue of classified items; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module tcw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tcw_pkg::q_entry_t   push_entry,
    input  logic                pop,
    output tcw_pkg::q_entry_t   head_entry,
    output logic                full,
    output logic                empty
);

    tcw_pkg::q_entry_t              entries_reg [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [tcw_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [tcw_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [tcw_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [tcw_pkg::QCNT_W-1:0]     count_reg;
    logic [tcw_pkg::QCNT_W-1:0]     count_next;

    assign full       = (count_reg == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back : screen store, cursor and command execution
// Runs the clearing pass, character writes, cell reads and scrolls, and
// holds the result register.
// ----------------------------------------------------------------------------
module tcw_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_enable,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_write_data,
    input  tcw_pkg::q_entry_t             head_entry,
    input  logic                          q_empty,
    output logic                          pop,
    output logic                          clearing,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tcw_pkg::CELL_W-1:0]    cell_data,
    output logic [tcw_pkg::POS_W-1:0]     cursor_position
);

    // screen store
    logic [tcw_pkg::CELL_W-1:0]   mem [tcw_pkg::CELL_COUNT];
    logic                         mem_we;
    logic [tcw_pkg::ADDR_W-1:0]   mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
    logic                         mem_re;
    logic [tcw_pkg::ADDR_W-1:0]   mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]   rd_data_reg;

    // control state
    tcw_pkg::back_state_t         state_reg;
    tcw_pkg::back_state_t         state_next;
    logic [tcw_pkg::CNT_W-1:0]    cnt_reg;
    logic [tcw_pkg::CNT_W-1:0]    cnt_next;
    logic [tcw_pkg::COL_W-1:0]    col_reg;
    logic [tcw_pkg::COL_W-1:0]    col_next;
    logic [tcw_pkg::ROW_W-1:0]    row_reg;
    logic [tcw_pkg::ROW_W-1:0]    row_next;
    logic [tcw_pkg::ATTR_W-1:0]   attr_reg;

    // scroll write stage
    logic                         stage_valid_reg;
    logic                         stage_valid_next;
    logic [tcw_pkg::ADDR_W-1:0]   stage_addr_reg;
    logic [tcw_pkg::ADDR_W-1:0]   stage_addr_next;
    logic                         stage_blank_reg;
    logic                         stage_blank_next;

    // read range flag
    logic                         read_oob_reg;
    logic                         read_oob_next;

    // result register
    logic                         out_valid_reg;
    logic [tcw_pkg::CELL_W-1:0]   cell_data_reg;
    logic [tcw_pkg::POS_W-1:0]    cursor_position_reg;
    logic                         out_load;
    logic [tcw_pkg::CELL_W-1:0]   out_cell;
    logic                         out_free;

    // cursor arithmetic
    logic [tcw_pkg::COL_X_W-1:0]  col_sum;
    logic                         advance;
    logic                         scroll_req;
    logic [tcw_pkg::ROW_W-1:0]    row_adv;
    logic                         put;
    logic [tcw_pkg::ADDR_W-1:0]   put_addr;
    logic [tcw_pkg::CHAR_W-1:0]   put_char;
    logic [tcw_pkg::ADDR_W-1:0]   cur_addr;
    logic [tcw_pkg::ADDR_W-1:0]   pos_next;
    logic                         start;
    logic [tcw_pkg::CELL_W-1:0]   blank_cell;

    assign out_free   = !out_valid_reg || out_ready;
    assign start      = (state_reg == tcw_pkg::ST_IDLE) && !q_empty && out_free;
    assign clearing   = (state_reg == tcw_pkg::ST_CLEAR);
    assign blank_cell = {attr_reg, tcw_pkg::CH_SPACE};

    assign cur_addr = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(row_reg)
                      * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS))
                      + tcw_pkg::ADDR_W'(col_reg);

    // new cursor for the write at the queue head
    always_comb
    begin
        col_sum  = {1'b0, col_reg};
        advance  = 1'b0;
        put      = 1'b0;
        put_addr = cur_addr;
        put_char = tcw_pkg::CH_SPACE;
        case (head_entry.op)
            tcw_pkg::OP_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    col_sum  = {1'b0, col_reg} - 1'b1;
                    put      = 1'b1;
                    put_addr = cur_addr - 1'b1;
                end
            end
            tcw_pkg::OP_TAB:
            begin
                col_sum = ({1'b0, col_reg} + tcw_pkg::COL_X_W'(tcw_pkg::TAB_STEP))
                          & ~tcw_pkg::COL_X_W'(tcw_pkg::TAB_STEP - 1);
            end
            tcw_pkg::OP_RETURN:
            begin
                col_sum = '0;
            end
            tcw_pkg::OP_NEWLINE:
            begin
                col_sum = '0;
                advance = 1'b1;
            end
            tcw_pkg::OP_PUT:
            begin
                put      = 1'b1;
                put_char = head_entry.char_code;
                col_sum  = {1'b0, col_reg} + 1'b1;
            end
            default:
            begin
            end
        endcase
        // wrap at the right edge
        if (col_sum >= tcw_pkg::COL_X_W'(tcw_pkg::COLUMNS))
        begin
            col_sum = '0;
            advance = 1'b1;
        end
        // bottom edge scrolls, cursor stays on the last row
        scroll_req = advance && (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
        row_adv    = (advance && !scroll_req) ? row_reg + 1'b1 : row_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_CLEAR:
            begin
                if (cnt_reg == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1))
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (head_entry.op == tcw_pkg::OP_READ)
                    begin
                        state_next = tcw_pkg::ST_READ;
                    end
                    else if (scroll_req)
                    begin
                        state_next = tcw_pkg::ST_SCROLL;
                    end
                end
            end
            tcw_pkg::ST_READ:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_SCROLL:
            begin
                if (cnt_reg == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT))
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;
        cnt_next         = cnt_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        pop              = 1'b0;
        out_load         = 1'b0;
        out_cell         = '0;
        stage_valid_next = 1'b0;
        stage_addr_next  = '0;
        stage_blank_next = 1'b0;
        read_oob_next    = read_oob_reg;

        // delayed write of a scroll copy or blank
        if (stage_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = stage_addr_reg;
            mem_wdata = stage_blank_reg ? blank_cell : rd_data_reg;
        end

        case (state_reg)
            tcw_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = tcw_pkg::ADDR_W'(cnt_reg);
                mem_wdata = '0;
                if (cnt_reg == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1))
                begin
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    pop = 1'b1;
                    if (head_entry.op == tcw_pkg::OP_READ)
                    begin
                        mem_re        = 1'b1;
                        mem_raddr     = tcw_pkg::ADDR_W'(head_entry.cell_index);
                        read_oob_next = (32'(head_entry.cell_index)
                                         >= 32'(tcw_pkg::CELL_COUNT));
                    end
                    else
                    begin
                        col_next = col_sum[tcw_pkg::COL_W-1:0];
                        row_next = row_adv;
                        if (put)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = put_addr;
                            mem_wdata = {attr_reg, put_char};
                        end
                        if (scroll_req)
                        begin
                            cnt_next = '0;
                        end
                        else
                        begin
                            out_load = 1'b1;
                        end
                    end
                end
            end
            tcw_pkg::ST_READ:
            begin
                out_load = 1'b1;
                out_cell = read_oob_reg ? '0 : rd_data_reg;
            end
            tcw_pkg::ST_SCROLL:
            begin
                if (cnt_reg != tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT))
                begin
                    // copy rows up, then blank the bottom row
                    if (cnt_reg < tcw_pkg::CNT_W'(tcw_pkg::COPY_COUNT))
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = tcw_pkg::ADDR_W'(cnt_reg
                                    + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS));
                    end
                    stage_valid_next = 1'b1;
                    stage_addr_next  = tcw_pkg::ADDR_W'(cnt_reg);
                    stage_blank_next = (cnt_reg >= tcw_pkg::CNT_W'(tcw_pkg::COPY_COUNT));
                    cnt_next         = cnt_reg + 1'b1;
                end
                else
                begin
                    out_load = 1'b1;
                    cnt_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign pos_next = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(row_next)
                      * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS))
                      + tcw_pkg::ADDR_W'(col_next);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tcw_pkg::ST_CLEAR;
            cnt_reg         <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            attr_reg        <= tcw_pkg::ATTR_RESET;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            stage_valid_reg <= stage_valid_next;
            if (cfg_write_enable)
            begin
                attr_reg <= cfg_write_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        stage_addr_reg  <= stage_addr_next;
        stage_blank_reg <= stage_blank_next;
        read_oob_reg    <= read_oob_next;
        if (out_load)
        begin
            cell_data_reg       <= out_cell;
            cursor_position_reg <= tcw_pkg::POS_W'(pos_next);
        end
    end

    // screen store ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign out_valid       = out_valid_reg;
    assign cell_data       = cell_data_reg;
    assign cursor_position = cursor_position_reg;

endmodule

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer : character-cell text console
// Front end classifies beats, a short queue decouples it from the back end
// that owns the screen store and cursor.
// ----------------------------------------------------------------------------
// Throughput: one write per cycle while out_ready holds and no scroll runs; a read
//   waits in a read state for the registered store read before the next item.
// A write that scrolls copies rows up and blanks the bottom row, one cell per cycle.
// Reset: cursor to 0, attribute to 0x0F, then a clearing pass zeroes the screen
//   while in_ready stays low.
module text_console_writer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_enable,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tcw_pkg::CELL_W-1:0]    cell_data,
    output logic [tcw_pkg::POS_W-1:0]     cursor_position
);

    logic               push;
    tcw_pkg::q_entry_t  push_entry;
    tcw_pkg::q_entry_t  head_entry;
    logic               q_full;
    logic               q_empty;
    logic               pop;
    logic               clearing;

    // accept and classify
    tcw_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .char_code  (char_code),
        .cell_index (cell_index),
        .clearing   (clearing),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue
    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    // execute
    tcw_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .head_entry       (head_entry),
        .q_empty          (q_empty),
        .pop              (pop),
        .clearing         (clearing),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .cell_data        (cell_data),
        .cursor_position  (cursor_position)
    );

endmodule
